/* hw/rtl/per_peer_replay_window_check_top_assert.svh */
// Assertion macros for the per-peer replay window check.
`ifndef PER_PEER_REPLAY_WINDOW_CHECK_TOP_ASSERT_SVH
`define PER_PEER_REPLAY_WINDOW_CHECK_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold on the cycle after the antecedent.
`define PPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("replay window check: next-cycle property failed");
// The condition must never be true.
`define PPR_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("replay window check: forbidden condition seen");
`else
`define PPR_ASSERT_NEXT(label, ante, cons)
`define PPR_ASSERT_NEVER(label, cond)
`endif

`endif

/* hw/rtl/ppr_pkg.sv */
// Shared types and constants of the per-peer replay window check.
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int ID_W       = 16;
    localparam int SEQ_W      = 32;
    localparam int VERDICT_W  = 3;
    localparam int SLOT_OUT_W = 5;

    localparam logic [VERDICT_W-1:0] VERDICT_ADVANCE = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NEWPEER = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FILL    = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_DUP     = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_OLD     = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL    = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_OFF     = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the input item, search the table, read the entry
        logic commit;   // update the entry and load the result register
    } ppr_cmd_t;

endpackage

/* hw/rtl/ppr_ctrl.sv */
// Controller of the per-peer replay window check: sequencing and output handshake.
`timescale 1ns / 1ps

module ppr_ctrl
    import ppr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ppr_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result register must be free or emptying this cycle.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* hw/rtl/ppr_datapath.sv */
// Datapath of the per-peer replay window check: peer table, entry memory and window update.
`timescale 1ns / 1ps

module ppr_datapath
    import ppr_pkg::*;
#(
    parameter int MAX_PEERS   = 32,
    parameter int WINDOW_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppr_cmd_t              cmd,
    input  logic [ID_W-1:0]       in_id,
    input  logic [SEQ_W-1:0]      in_seq,
    input  logic                  cfg_we,
    input  logic                  cfg_enable,
    output logic                  out_accepted,
    output logic [VERDICT_W-1:0]  out_verdict,
    output logic [SLOT_OUT_W-1:0] out_slot
);

    localparam int SLOT_W  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int PC_W    = $clog2(MAX_PEERS + 1);
    localparam int SH_W    = $clog2(WINDOW_BITS);
    localparam int ENTRY_W = SEQ_W + WINDOW_BITS;

    logic                   enable_reg;
    logic [PC_W-1:0]        count_reg;
    logic [ID_W-1:0]        peer_id_reg [MAX_PEERS];
    logic [ENTRY_W-1:0]     entry_mem [MAX_PEERS];
    logic [ENTRY_W-1:0]     rd_data_reg;

    logic [ID_W-1:0]        id_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic                   hit_reg;
    logic [SLOT_W-1:0]      slot_reg;

    logic                   out_accepted_reg;
    logic [VERDICT_W-1:0]   out_verdict_reg;
    logic [SLOT_OUT_W-1:0]  out_slot_reg;

    // Search of the table, on the item as it is accepted.
    logic                   hit_next;
    logic [SLOT_W-1:0]      slot_next;

    always_comb
    begin
        hit_next  = 1'b0;
        slot_next = '0;
        for (int i = MAX_PEERS - 1; i >= 0; i--)
        begin
            if ((PC_W'(i) < count_reg) && (peer_id_reg[i] == in_id))
            begin
                hit_next  = 1'b1;
                slot_next = SLOT_W'(i);
            end
        end
    end

    // Update of the entry read for the captured item.
    logic [SEQ_W-1:0]        last_seq;
    logic [WINDOW_BITS-1:0]  bitmap;
    logic [SEQ_W-1:0]        diff;
    logic [SEQ_W-1:0]        off;
    logic [WINDOW_BITS-1:0]  off_bit;
    logic                    room;
    logic                    wr_en;
    logic                    new_peer;
    logic [SLOT_W-1:0]       wr_slot;
    logic [ENTRY_W-1:0]      wr_data;
    logic                    acc_next;
    logic [VERDICT_W-1:0]    verdict_next;
    logic [SLOT_W-1:0]       sel_slot;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

    assign last_seq = rd_data_reg[SEQ_W-1:0];
    assign bitmap   = rd_data_reg[ENTRY_W-1:SEQ_W];
    assign diff     = seq_reg - last_seq;
    assign off      = last_seq - seq_reg;
    assign off_bit  = WINDOW_BITS'(1) << off[SH_W-1:0];
    assign room     = (count_reg < PC_W'(MAX_PEERS));

    always_comb
    begin
        wr_en        = 1'b0;
        new_peer     = 1'b0;
        wr_slot      = slot_reg;
        wr_data      = rd_data_reg;
        acc_next     = 1'b1;
        verdict_next = VERDICT_OFF;
        sel_slot     = '0;
        if (enable_reg)
        begin
            if (hit_reg)
            begin
                sel_slot = slot_reg;
                if (seq_reg > last_seq)
                begin
                    verdict_next = VERDICT_ADVANCE;
                    wr_en        = 1'b1;
                    if (diff < SEQ_W'(WINDOW_BITS))
                        wr_data = {(bitmap << diff[SH_W-1:0]) | WINDOW_BITS'(1), seq_reg};
                    else
                        wr_data = {WINDOW_BITS'(1), seq_reg};
                end
                else if (off < SEQ_W'(WINDOW_BITS))
                begin
                    if ((bitmap & off_bit) != '0)
                    begin
                        verdict_next = VERDICT_DUP;
                        acc_next     = 1'b0;
                    end
                    else
                    begin
                        verdict_next = VERDICT_FILL;
                        wr_en        = 1'b1;
                        wr_data      = {bitmap | off_bit, last_seq};
                    end
                end
                else
                begin
                    verdict_next = VERDICT_OLD;
                    acc_next     = 1'b0;
                end
            end
            else if (room)
            begin
                verdict_next = VERDICT_NEWPEER;
                new_peer     = 1'b1;
                wr_en        = 1'b1;
                wr_slot      = count_reg[SLOT_W-1:0];
                sel_slot     = count_reg[SLOT_W-1:0];
                wr_data      = {WINDOW_BITS'(1), seq_reg};
            end
            else
            begin
                verdict_next = VERDICT_FULL;
            end
        end
    end

    assign slot_wide = {{SLOT_OUT_W{1'b0}}, sel_slot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_enable;
            if (cmd.commit && new_peer)
                count_reg <= count_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg      <= in_id;
            seq_reg     <= in_seq;
            hit_reg     <= hit_next;
            slot_reg    <= slot_next;
            rd_data_reg <= entry_mem[slot_next];
        end
        if (cmd.commit && wr_en)
            entry_mem[wr_slot] <= wr_data;
        if (cmd.commit && new_peer)
            peer_id_reg[count_reg[SLOT_W-1:0]] <= id_reg;
        if (cmd.commit)
        begin
            out_accepted_reg <= acc_next;
            out_verdict_reg  <= verdict_next;
            out_slot_reg     <= slot_wide[SLOT_OUT_W-1:0];
        end
    end

    assign out_accepted = out_accepted_reg;
    assign out_verdict  = out_verdict_reg;
    assign out_slot     = out_slot_reg;

endmodule

/* hw/rtl/per_peer_replay_window_check_top.sv */
// Top level of the per-peer replay window check.
`timescale 1ns / 1ps

// Each item names a sender and a sequence number and comes back as one result
// item saying whether the packet is accepted, why, and which table slot it
// used. Each item is handled in a capture step and an update step: in the
// cycle it is accepted the sender id is compared against all valid slots of the
// peer table at once and the matching entry (highest sequence and window
// bitmap) is read from the entry memory; then, once the output register is free
// or emptying, the entry is updated and the result is loaded into the output
// register. The split comes from the single read port of the entry memory,
// whose data is registered. The input side stays ready while a finished result
// waits to be taken, so an item is held only when the output register is still
// full at the update cycle. The table needs no clearing after reset: only slots
// below the peer count are ever looked at. Checking can be turned off through
// the configuration channel, which should only be written while no item is in
// flight; with checking off every item is accepted and nothing is changed.

module per_peer_replay_window_check_top
    import ppr_pkg::*;
#(
    parameter int MAX_PEERS   = 32,
    parameter int WINDOW_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] sender_id, [47:16] sequence_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [4:0] peer_slot, [7:5] zero
    output logic [3:0]  m_tuser,   // [0] accepted, [3:1] verdict
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // replay_check_enable
);

    ppr_cmd_t              cmd;
    logic                  out_accepted;
    logic [VERDICT_W-1:0]  out_verdict;
    logic [SLOT_OUT_W-1:0] out_slot;

    // The enable register can always be written.
    assign cfg_ready = 1'b1;

    ppr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ppr_datapath #(
        .MAX_PEERS   (MAX_PEERS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_id        (s_tdata[ID_W-1:0]),
        .in_seq       (s_tdata[ID_W+SEQ_W-1:ID_W]),
        .cfg_we       (cfg_valid),
        .cfg_enable   (cfg_data),
        .out_accepted (out_accepted),
        .out_verdict  (out_verdict),
        .out_slot     (out_slot)
    );

    assign m_tdata = {3'b000, out_slot};
    assign m_tuser = {out_verdict, out_accepted};

    // A committed item always shows up at the output on the next cycle.
    `include "per_peer_replay_window_check_top_assert.svh"
    `PPR_ASSERT_NEXT(a_commit_loads_output, cmd.commit, m_tvalid)
    // Only one item is in flight: after an acceptance the input side closes.
    `PPR_ASSERT_NEXT(a_one_in_flight, cmd.capture, !s_tready)
    // Capture and update of the entry never fall in the same cycle.
    `PPR_ASSERT_NEVER(a_capture_commit_apart, cmd.capture && cmd.commit)
    // Rejected items are only duplicates or too old.
    `PPR_ASSERT_NEVER(a_reject_reason, m_tvalid && !m_tuser[0] &&
        (m_tuser[3:1] != VERDICT_DUP) && (m_tuser[3:1] != VERDICT_OLD))

endmodule
